// ----- hdl/tng_pkg.sv -----
// Shared types, constants and the attenuation table of the tone and noise sound generator.
// Used by every module of the block; depends on nothing.
package tng_pkg;

	// Fixed-point format of the phase increment: whole chip clocks above this bit.
	localparam int PHASE_FRAC_BITS = 24;
	localparam int PHASE_WIDTH     = 32;
	localparam logic [PHASE_WIDTH-1:0] PHASE_INC_RESET = 32'd212779193;

	localparam int CLOCKS_WIDTH  = 8;
	localparam int CHANNELS      = 4;
	localparam int PERIOD_WIDTH  = 12;
	localparam int COUNTER_WIDTH = 16;
	localparam int AMP_WIDTH     = 8;
	localparam int REG_WIDTH     = 10;
	localparam int NOISE_WIDTH   = 15;
	localparam int SAMPLE_WIDTH  = 9;
	localparam int MIX_WIDTH     = 11;

	localparam logic [PERIOD_WIDTH-1:0] TONE_PERIOD_ZERO = 12'h400;
	localparam logic [PERIOD_WIDTH-1:0] NOISE_PERIOD_MIN = 12'd32;
	localparam logic [NOISE_WIDTH-1:0]  NOISE_SEED       = 15'h4000;

	// Item kinds carried in the input tuser bit.
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

	// Register numbers of the register file.
	localparam logic [2:0] REG_TONE0 = 3'd0;
	localparam logic [2:0] REG_VOL0  = 3'd1;
	localparam logic [2:0] REG_TONE1 = 3'd2;
	localparam logic [2:0] REG_VOL1  = 3'd3;
	localparam logic [2:0] REG_TONE2 = 3'd4;
	localparam logic [2:0] REG_VOL2  = 3'd5;
	localparam logic [2:0] REG_NOISE = 3'd6;
	localparam logic [2:0] REG_VOL3  = 3'd7;

	// Noise mode that ties the noise period to tone 2.
	localparam logic [1:0] NOISE_MODE_TONE2 = 2'd3;

	// Channel numbers.
	localparam int CH_TONE2 = 2;
	localparam int CH_NOISE = 3;

	// Decoded register state handed from the register block to the mixer.
	typedef struct packed {
		logic [CHANNELS-1:0][PERIOD_WIDTH-1:0] period;
		logic [CHANNELS-1:0][AMP_WIDTH-1:0]    amp;
		logic                                  white;
	} tng_regs_t;

	// Attenuation steps of roughly 2 dB, the last step silent.
	function automatic logic [AMP_WIDTH-1:0] atten_lookup(input logic [3:0] idx);
		logic [AMP_WIDTH-1:0] amp;
		unique case (idx)
			4'd0:  amp = 8'd255;
			4'd1:  amp = 8'd202;
			4'd2:  amp = 8'd160;
			4'd3:  amp = 8'd127;
			4'd4:  amp = 8'd101;
			4'd5:  amp = 8'd80;
			4'd6:  amp = 8'd64;
			4'd7:  amp = 8'd50;
			4'd8:  amp = 8'd40;
			4'd9:  amp = 8'd32;
			4'd10: amp = 8'd25;
			4'd11: amp = 8'd20;
			4'd12: amp = 8'd16;
			4'd13: amp = 8'd12;
			4'd14: amp = 8'd9;
			4'd15: amp = 8'd0;
		endcase
		return amp;
	endfunction

endpackage

// ----- hdl/tng_phase.sv -----
// Fractional phase accumulator and the phase increment register.
// Depends on tng_pkg.
module tng_phase import tng_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [PHASE_WIDTH-1:0]  cfg_data,
	input  logic                    advance,
	output logic [CLOCKS_WIDTH-1:0] clocks
);

	logic [PHASE_WIDTH-1:0]     inc_q;
	logic [PHASE_FRAC_BITS-1:0] frac_q;
	logic [PHASE_WIDTH-1:0]     sum;

	// The sum wraps at the word width; its whole part is the clock count of this sample.
	assign sum    = {{(PHASE_WIDTH-PHASE_FRAC_BITS){1'b0}}, frac_q} + inc_q;
	assign clocks = sum[PHASE_FRAC_BITS +: CLOCKS_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q  <= PHASE_INC_RESET;
			frac_q <= '0;
		end else begin
			if (cfg_valid) begin
				inc_q <= cfg_data;
			end
			if (advance) begin
				frac_q <= sum[PHASE_FRAC_BITS-1:0];
			end
		end
	end

endmodule

// ----- hdl/tng_counter.sv -----
// Period counter of one channel: adds the clock count and flags at most one toggle per sample.
// Depends on tng_pkg.
module tng_counter import tng_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [CLOCKS_WIDTH-1:0] clocks,
	input  logic [PERIOD_WIDTH-1:0] period,
	output logic                    toggle
);

	logic [COUNTER_WIDTH-1:0] count_q;
	logic [COUNTER_WIDTH-1:0] sum;
	logic [COUNTER_WIDTH-1:0] period_ext;
	logic                     hit;

	assign sum        = count_q + {{(COUNTER_WIDTH-CLOCKS_WIDTH){1'b0}}, clocks};
	assign period_ext = {{(COUNTER_WIDTH-PERIOD_WIDTH){1'b0}}, period};
	// A zero period never toggles.
	assign hit        = (period != '0) && (sum >= period_ext);
	assign toggle     = step && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= hit ? (sum - period_ext) : sum;
		end
	end

endmodule

// ----- hdl/tng_regs.sv -----
// Latch/data register file with the decoded periods, amplitudes and noise controls.
// Depends on tng_pkg.
module tng_regs import tng_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [7:0] wr_byte,
	output tng_regs_t  regs,
	output logic       reseed
);

	logic [REG_WIDTH-1:0] rf_q [8];
	logic [2:0]           latch_q;
	tng_regs_t            regs_q;

	logic [2:0]              sel;
	logic [REG_WIDTH-1:0]    cur;
	logic [REG_WIDTH-1:0]    new_val;
	logic [PERIOD_WIDTH-1:0] tone_period;
	logic [1:0]              mode;
	logic [PERIOD_WIDTH-1:0] noise_period;

	// A byte with bit 7 set latches a register and writes its low nibble; otherwise
	// the byte writes the high six bits of the latched register.
	assign sel     = wr_byte[7] ? wr_byte[6:4] : latch_q;
	assign cur     = rf_q[sel];
	assign new_val = wr_byte[7] ? {cur[9:4], wr_byte[3:0]} : {wr_byte[5:0], cur[3:0]};

	assign tone_period = (new_val == '0) ? TONE_PERIOD_ZERO
		: {{(PERIOD_WIDTH-REG_WIDTH){1'b0}}, new_val};

	assign mode = new_val[1:0];
	assign noise_period = (mode == NOISE_MODE_TONE2)
		? {regs_q.period[CH_TONE2][PERIOD_WIDTH-2:0], 1'b0}
		: (NOISE_PERIOD_MIN << mode);

	assign reseed = wr_en && (sel == REG_NOISE);
	assign regs   = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
			latch_q <= '0;
			regs_q  <= '0;
		end else if (wr_en) begin
			latch_q   <= sel;
			rf_q[sel] <= new_val;
			unique case (sel)
				REG_TONE0, REG_TONE1, REG_TONE2: begin
					regs_q.period[sel[2:1]] <= tone_period;
					if ((sel == REG_TONE2) && (rf_q[REG_NOISE][1:0] == NOISE_MODE_TONE2)) begin
						regs_q.period[CH_NOISE] <= {tone_period[PERIOD_WIDTH-2:0], 1'b0};
					end
				end
				REG_NOISE: begin
					regs_q.period[CH_NOISE] <= noise_period;
					regs_q.white            <= new_val[2];
				end
				REG_VOL0, REG_VOL1, REG_VOL2, REG_VOL3: begin
					// The amplitude follows the low nibble of the byte itself.
					regs_q.amp[sel[2:1]] <= atten_lookup(wr_byte[3:0]);
				end
			endcase
		end
	end

endmodule

// ----- hdl/tone_noise_sound_generator.sv -----
// Top level of the tone and noise sound generator: input stage, channel mixer and output stage.
// Depends on tng_pkg, tng_regs, tng_phase and tng_counter.
//
// Usage:
// The slave stream (s_tvalid, s_tready, s_tdata, s_tuser) carries one item per beat. When
// s_tuser is low the beat is a register byte in the latch/data format; it updates the register
// file and returns nothing. When s_tuser is high the beat renders one audio sample, which
// leaves on the master stream (m_tvalid, m_tready, m_tdata) as a 9-bit two's complement value.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the phase increment, the
// number of chip clocks per sample with 24 fractional bits; it is always ready and must only
// be written while no item is in flight.
// Each accepted beat is captured in an input register and handled from there by
// single-pass logic (one phase add, then a 16-bit add and compare per channel, then the mix),
// whose sample is written into the output register that drives m_tvalid. One beat per cycle is
// sustained as long as the receiver keeps m_tready high.
// When the receiver stalls, a sample waits in the output register; a render beat held in the
// input register then waits too, and s_tready falls. Register writes in the input register
// still go through during a stall, since they produce no beat.
// Reset clears the register file, the periods, the amplitudes, the counters and polarities,
// reloads the noise shift register with its seed and the phase increment with its default.
module tone_noise_sound_generator import tng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: phase increment.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] func: 0 = register byte, 1 = render a sample
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [8:0] sample (signed), [15:9] zero
);

	// Input stage.
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	// Output stage.
	logic                    m_valid_q;
	logic [SAMPLE_WIDTH-1:0] sample_q;

	// Channel state kept here: polarities and the noise shift register.
	logic [CHANNELS-1:0]    pol_q;
	logic [NOISE_WIDTH-1:0] noise_q;

	logic                    out_free;
	logic                    go;
	logic                    do_write;
	logic                    do_render;
	logic                    step;
	logic [CLOCKS_WIDTH-1:0] clocks;
	logic [CHANNELS-1:0]     toggle;
	logic [CHANNELS-1:0]     pol_next;
	logic                    noise_fb;
	logic                    reseed;
	tng_regs_t               regs;

	logic signed [MIX_WIDTH-1:0] term [CHANNELS];
	logic signed [MIX_WIDTH-1:0] mix;
	logic [SAMPLE_WIDTH-1:0]     sample;

	// The item in the input stage moves on when it is a register byte, or when the output
	// register is empty or being emptied in this cycle.
	assign out_free  = !m_valid_q || m_tready;
	assign go        = valid_s1 && ((func_s1 == FUNC_WRITE) || out_free);
	assign do_write  = go && (func_s1 == FUNC_WRITE);
	assign do_render = go && (func_s1 == FUNC_RENDER);
	assign s_tready  = !valid_s1 || go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	tng_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (do_write),
		.wr_byte (byte_s1),
		.regs    (regs),
		.reseed  (reseed)
	);

	tng_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.advance   (do_render),
		.clocks    (clocks)
	);

	// A sample that covers no whole chip clock leaves every channel untouched.
	assign step = do_render && (clocks != '0);

	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		tng_counter u_counter (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.clocks (clocks),
			.period (regs.period[g]),
			.toggle (toggle[g])
		);
	end

	// Tones flip on each toggle; the noise polarity is the bit shifted out next.
	assign noise_fb = noise_q[0] ^ (noise_q[1] & regs.white);

	always_comb begin
		for (int i = 0; i < CH_NOISE; i++) begin
			pol_next[i] = pol_q[i] ^ toggle[i];
		end
		pol_next[CH_NOISE] = toggle[CH_NOISE] ? noise_q[1] : pol_q[CH_NOISE];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q   <= '0;
			noise_q <= NOISE_SEED;
		end else begin
			pol_q <= pol_next;
			if (reseed) begin
				noise_q <= NOISE_SEED;
			end else if (toggle[CH_NOISE]) begin
				noise_q <= {noise_fb, noise_q[NOISE_WIDTH-1:1]};
			end
		end
	end

	// Mix of the four signed amplitudes, divided by four with rounding toward minus infinity.
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			term[i] = pol_next[i]
				? $signed({{(MIX_WIDTH-AMP_WIDTH){1'b0}}, regs.amp[i]})
				: -$signed({{(MIX_WIDTH-AMP_WIDTH){1'b0}}, regs.amp[i]});
		end
		mix = term[0] + term[1] + term[2] + term[3];
	end

	assign sample = (clocks == '0) ? '0 : mix[MIX_WIDTH-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (do_render) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_render) begin
			sample_q <= sample;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(16-SAMPLE_WIDTH){1'b0}}, sample_q};

endmodule
